// ===== rtl/hpcs_pkg.sv =====
// Shared types, codes and the gamma table generator of the contrast stretch block.
package hpcs_pkg;

	// Pass selector codes on the func input.
	localparam logic [1:0] FUNC_SCAN = 2'd0;
	localparam logic [1:0] FUNC_FILL = 2'd1;
	localparam logic [1:0] FUNC_MAP  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_CLIP_BRIGHT = 1'b0;
	localparam logic REG_BIN_COUNT   = 1'b1;

	localparam int CFG_W          = 11;
	localparam logic [CFG_W-1:0] BIN_COUNT_RESET = 11'd1024;
	localparam int QDEPTH         = 4;
	localparam int QPTR_W         = 2;
	localparam int OUT_W          = 16;

	typedef enum logic [1:0] {
		K_SCAN,
		K_FILL,
		K_MAP,
		K_NONE
	} hpcs_kind_t;

	typedef struct packed {
		hpcs_kind_t kind;
		logic       last;
	} hpcs_item_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BDIV,
		S_BRD,
		S_BINC,
		S_PEAK,
		S_LDIV,
		S_LSET,
		S_RDIV,
		S_MMUL,
		S_MTAB,
		S_MOUT
	} hpcs_state_t;

	// Pseudo float with a 32-bit mantissa, truncating after each multiply.
	typedef struct packed {
		logic [63:0]        m;
		logic signed [31:0] e;
	} hpcs_pf_t;

	function automatic hpcs_pf_t pf_from(logic [63:0] v);
		hpcs_pf_t r;
		r.m = v;
		r.e = 0;
		while (r.m >= 64'h1_0000_0000) begin
			r.m = r.m >> 1;
			r.e = r.e + 1;
		end
		while (r.m < 64'h8000_0000) begin
			r.m = r.m << 1;
			r.e = r.e - 1;
		end
		return r;
	endfunction

	function automatic hpcs_pf_t pf_mul(hpcs_pf_t a, hpcs_pf_t b);
		hpcs_pf_t    r;
		logic [63:0] p;
		p = a.m * b.m;
		r.e = a.e + b.e;
		if (p[63]) begin
			r.m = p >> 32;
			r.e = r.e + 32;
		end else begin
			r.m = p >> 31;
			r.e = r.e + 31;
		end
		return r;
	endfunction

	function automatic hpcs_pf_t pf_pow(hpcs_pf_t a, int n);
		hpcs_pf_t r;
		r = a;
		for (int i = 1; i < n; i++) begin
			r = pf_mul(r, a);
		end
		return r;
	endfunction

	function automatic logic pf_le(hpcs_pf_t a, hpcs_pf_t b);
		return (a.e < b.e) || ((a.e == b.e) && (a.m <= b.m));
	endfunction

	// Entry k of the x^0.3 table: largest y with y^10 * N^3 <= k^3 * 65535^10.
	function automatic logic [15:0] hpcs_gamma(int k, int gbits);
		hpcs_pf_t    full10;
		hpcs_pf_t    n3;
		hpcs_pf_t    rhs;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] mid;
		if (k == 0) begin
			return 16'd0;
		end
		full10 = pf_pow(pf_from(64'd65535), 10);
		n3     = pf_pow(pf_from(64'd1 << gbits), 3);
		rhs    = pf_mul(pf_pow(pf_from(64'(k)), 3), full10);
		lo = 32'd1;
		hi = 32'd65535;
		while (lo < hi) begin
			mid = lo + ((hi - lo + 32'd1) >> 1);
			if (pf_le(pf_mul(pf_pow(pf_from(64'(mid)), 10), n3), rhs)) begin
				lo = mid;
			end else begin
				hi = mid - 32'd1;
			end
		end
		return lo[15:0];
	endfunction

endpackage

// ===== rtl/hpcs_front.sv =====
// Input queue that accepts pixels, classifies them by pass and holds them for the back end.
module hpcs_front #(
	parameter int PIXEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	output logic                  full,
	input  logic [1:0]            func,
	input  logic [PIXEL_BITS-1:0] pixel,
	input  logic                  last,
	input  logic                  hold,
	output logic                  item_valid,
	output hpcs_pkg::hpcs_item_t  item,
	output logic [PIXEL_BITS-1:0] item_pixel,
	input  logic                  item_take
);
	import hpcs_pkg::*;

	hpcs_item_t            ent_q [QDEPTH];
	logic [PIXEL_BITS-1:0] pix_q [QDEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QPTR_W:0]       cnt_q;
	logic                  accept;
	logic                  pop_q;
	hpcs_item_t            cls;

	always_comb begin
		cls.last = last;
		case (func)
			FUNC_SCAN: cls.kind = K_SCAN;
			FUNC_FILL: cls.kind = K_FILL;
			FUNC_MAP:  cls.kind = K_MAP;
			default:   cls.kind = K_NONE;
		endcase
	end

	assign full       = (cnt_q == (QPTR_W+1)'(QDEPTH)) || hold;
	assign accept     = push && !full;
	assign item_valid = (cnt_q != '0);
	assign pop_q      = item_take && item_valid;
	assign item       = ent_q[rd_ptr_q];
	assign item_pixel = pix_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_q) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (accept && !pop_q) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!accept && pop_q) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wr_ptr_q] <= cls;
			pix_q[wr_ptr_q] <= pixel;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QPTR_W+1)'(QDEPTH))
		else $error("input queue count beyond depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !pop_q) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("input queue lost a transfer");
	assert property (@(posedge clk) disable iff (!arst_n)
		hold |-> !accept)
		else $error("transfer taken while input is held");

endmodule

// ===== rtl/hpcs_div.sv =====
// Restoring divider that produces one quotient bit per cycle.
module hpcs_div #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             busy,
	output logic             done,
	output logic [NUM_W-1:0] quo
);
	localparam int CNT_W = $clog2(NUM_W);

	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   rem_sh;
	logic [DEN_W+1:0] diff;
	logic             qbit;

	assign rem_sh = {rem_q[DEN_W-1:0], quo_q[NUM_W-1]};
	assign diff   = {1'b0, rem_sh} - {2'b00, den_q};
	assign qbit   = !diff[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				quo_q  <= num;
				den_q  <= den;
				rem_q  <= '0;
				cnt_q  <= CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				rem_q <= qbit ? diff[DEN_W:0] : rem_sh;
				quo_q <= {quo_q[NUM_W-2:0], qbit};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = quo_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still stepping");
	assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < {1'b0, den_q}))
		else $error("partial remainder not below divisor");

endmodule

// ===== rtl/hpcs_back.sv =====
// Execution side: min/max scan, histogram, peak search, cut setup and gamma mapping.
module hpcs_back #(
	parameter int MAX_BINS         = 1024,
	parameter int PIXEL_BITS       = 16,
	parameter int COUNT_BITS       = 20,
	parameter int GAMMA_TABLE_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clip_bright,
	input  logic [hpcs_pkg::CFG_W-1:0]  bin_count,
	input  logic                        item_valid,
	input  hpcs_pkg::hpcs_item_t        item,
	input  logic [PIXEL_BITS-1:0]       item_pixel,
	output logic                        item_take,
	output logic                        hold,
	output logic                        res_valid,
	input  logic                        res_pop,
	output logic [hpcs_pkg::OUT_W-1:0]  mapped,
	output logic                        frame_end,
	output logic [PIXEL_BITS-1:0]       cut_low,
	output logic [PIXEL_BITS-1:0]       cut_high
);
	import hpcs_pkg::*;

	localparam int PB     = PIXEL_BITS;
	localparam int BIN_W  = $clog2(MAX_BINS + 1);
	localparam int ADDR_W = $clog2(MAX_BINS);
	localparam int CW     = (BIN_W > CFG_W) ? BIN_W : CFG_W;
	localparam int NUM_A  = PB + BIN_W + 2;
	localparam int NUM_W  = (NUM_A > 33) ? NUM_A : 33;
	localparam int DEN_W  = ((PB > BIN_W) ? PB : BIN_W) + 1;
	localparam int GT     = GAMMA_TABLE_BITS;
	localparam int GT_N   = 1 << GT;
	localparam int SH     = 16 - GT;
	localparam int PR_W   = PB + 32;

	// Constant x^0.3 table, built at elaboration.
	logic [OUT_W-1:0] gtab [GT_N+1];
	for (genvar k = 0; k <= GT_N; k++) begin : g_gtab
		localparam logic [OUT_W-1:0] GV = hpcs_gamma(k, GT);
		assign gtab[k] = GV;
	end

	hpcs_state_t state_q, state_n;

	// Bin memory and its clearing sweep.
	logic [COUNT_BITS-1:0] bins_mem [MAX_BINS];
	logic [COUNT_BITS-1:0] rd_q;
	logic [ADDR_W-1:0]     mem_ra;
	logic [ADDR_W-1:0]     mem_wa;
	logic [COUNT_BITS-1:0] mem_wd;
	logic                  mem_we;
	logic                  clr_busy_q;
	logic                  init_q;
	logic [ADDR_W-1:0]     clr_ptr_q;

	// Frame statistics and cuts.
	logic [PB-1:0]    min_q, max_q, lc_q, uc_q;
	logic [31:0]      recip_q;
	logic             hv_q;
	logic             scan_open_q;
	logic [PB-1:0]    pix_q;
	logic             last_q;
	logic [ADDR_W-1:0] idx_q;
	logic [BIN_W-1:0] pk_i_q;
	logic [ADDR_W-1:0] pk_idx_q;
	logic             pk_v_q;
	logic [ADDR_W-1:0] best_idx_q;
	logic [COUNT_BITS-1:0] best_cnt_q;

	// Mapping stages.
	logic [PR_W-1:0]  prod_s1;
	logic             ge_s1, le_s1;
	logic [OUT_W-1:0] ga_s2, gb_s2;
	logic [SH-1:0]    f_s2;
	logic             ge_s2, le_s2;

	// Result register.
	logic             out_v_q;
	logic [OUT_W-1:0] out_map_q;
	logic             out_end_q;
	logic [PB-1:0]    out_cl_q, out_ch_q;

	// Divider.
	logic             div_start, div_busy, div_done;
	logic [NUM_W-1:0] div_num, div_quo;
	logic [DEN_W-1:0] div_den;

	logic [BIN_W-1:0] b_eff, bm1;
	logic [PB-1:0]    span, d, span2;
	logic             fill_direct, issue, peak_end, out_free, span2_ok;
	logic [PB-1:0]    lc_n, hi_n, uc_n;
	logic [PB+15:0]   n_hi;
	logic [15:0]      n16;
	logic [GT-1:0]    ti;
	logic [OUT_W-1:0] gdiff;
	logic [OUT_W+SH-1:0] gprod;
	logic [OUT_W-1:0] map_val;
	logic [COUNT_BITS-1:0] inc_val;

	hpcs_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_comb begin
		if (CW'(bin_count) < CW'(3)) begin
			b_eff = BIN_W'(3);
		end else if (CW'(bin_count) > CW'(MAX_BINS)) begin
			b_eff = BIN_W'(MAX_BINS);
		end else begin
			b_eff = BIN_W'(bin_count);
		end
	end
	assign bm1         = b_eff - 1'b1;
	assign span        = (max_q > min_q) ? (max_q - min_q) : '0;
	assign d           = item_pixel - min_q;
	assign fill_direct = (span == '0) || (item_pixel <= min_q);
	assign issue       = pk_i_q < bm1;
	assign peak_end    = !issue && !pk_v_q;
	assign out_free    = !out_v_q || res_pop;
	assign span2       = uc_q - lc_q;
	assign span2_ok    = span2 >= PB'(2);
	assign inc_val     = (rd_q == '1) ? rd_q : rd_q + 1'b1;

	// Cut setup from the peak division result.
	always_comb begin
		lc_n = min_q + div_quo[PB-1:0];
		hi_n = (max_q > lc_n) ? max_q : lc_n;
		uc_n = clip_bright ? (hi_n - ((hi_n - lc_n) >> 1)) : hi_n;
	end

	// Gamma interpolation.
	always_comb begin
		n_hi    = prod_s1[PR_W-1:16];
		n16     = (n_hi[PB+15:16] != '0) ? 16'hFFFF : n_hi[15:0];
		ti      = n16[15:SH];
		gdiff   = gb_s2 - ga_s2;
		gprod   = (OUT_W+SH)'(gdiff) * (OUT_W+SH)'(f_s2);
		map_val = ge_s2 ? {OUT_W{hv_q}} :
			le_s2 ? '0 : (ga_s2 + gprod[OUT_W+SH-1:SH]);
	end

	// Next state.
	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					case (item.kind)
						K_FILL:  if (!clr_busy_q) state_n = fill_direct ? S_BRD : S_BDIV;
						K_MAP:   state_n = S_MMUL;
						default: state_n = S_IDLE;
					endcase
				end
			end
			S_BDIV:  if (div_done) state_n = S_BRD;
			S_BRD:   state_n = S_BINC;
			S_BINC:  state_n = last_q ? S_PEAK : S_IDLE;
			S_PEAK:  if (peak_end) state_n = S_LDIV;
			S_LDIV:  if (div_done) state_n = S_LSET;
			S_LSET:  state_n = span2_ok ? S_RDIV : S_IDLE;
			S_RDIV:  if (div_done) state_n = S_IDLE;
			S_MMUL:  state_n = S_MTAB;
			S_MTAB:  state_n = S_MOUT;
			S_MOUT:  if (out_free) state_n = S_IDLE;
			default: state_n = S_IDLE;
		endcase
	end

	// State outputs.
	always_comb begin
		item_take = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		mem_ra    = pk_i_q[ADDR_W-1:0];
		mem_we    = 1'b0;
		mem_wa    = idx_q;
		mem_wd    = inc_val;
		case (state_q)
			S_IDLE: begin
				item_take = item_valid && ((item.kind != K_FILL) || !clr_busy_q);
				div_start = item_take && (item.kind == K_FILL) && !fill_direct;
				div_num   = ((NUM_W'(d) * NUM_W'(bm1)) << 1) + NUM_W'(span);
				div_den   = DEN_W'(span) << 1;
			end
			S_BRD: begin
				mem_ra = idx_q;
			end
			S_BINC: begin
				mem_we = 1'b1;
			end
			S_PEAK: begin
				div_start = peak_end;
				div_num   = ((NUM_W'(best_idx_q) * NUM_W'(span)) << 1) + NUM_W'(bm1);
				div_den   = DEN_W'(bm1) << 1;
			end
			S_LSET: begin
				div_start = span2_ok;
				div_num   = NUM_W'(1) << 32;
				div_den   = DEN_W'(span2);
			end
			default: begin
				item_take = 1'b0;
			end
		endcase
		if (clr_busy_q) begin
			mem_we = 1'b1;
			mem_wa = clr_ptr_q;
			mem_wd = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bins_mem[mem_wa] <= mem_wd;
		end
		rd_q <= bins_mem[mem_ra];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_MTAB) begin
			ga_s2 <= gtab[{1'b0, ti}];
			gb_s2 <= gtab[(GT+1)'(ti) + 1'b1];
			f_s2  <= n16[SH-1:0];
			ge_s2 <= ge_s1;
			le_s2 <= le_s1;
		end
		if (state_q == S_MMUL) begin
			prod_s1 <= PR_W'(pix_q - lc_q) * PR_W'(recip_q);
			ge_s1   <= pix_q >= uc_q;
			le_s1   <= pix_q <= lc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clr_busy_q  <= 1'b1;
			init_q      <= 1'b1;
			clr_ptr_q   <= '0;
			min_q       <= '1;
			max_q       <= '0;
			lc_q        <= '0;
			uc_q        <= '1;
			recip_q     <= '0;
			hv_q        <= 1'b1;
			scan_open_q <= 1'b0;
			pix_q       <= '0;
			last_q      <= 1'b0;
			idx_q       <= '0;
			pk_i_q      <= '0;
			pk_idx_q    <= '0;
			pk_v_q      <= 1'b0;
			best_idx_q  <= '0;
			best_cnt_q  <= '0;
			out_v_q     <= 1'b0;
			out_map_q   <= '0;
			out_end_q   <= 1'b0;
			out_cl_q    <= '0;
			out_ch_q    <= '0;
		end else begin
			state_q <= state_n;

			if (clr_busy_q) begin
				clr_ptr_q <= clr_ptr_q + 1'b1;
				if (clr_ptr_q == ADDR_W'(MAX_BINS - 1)) begin
					clr_busy_q <= 1'b0;
					init_q     <= 1'b0;
				end
			end

			if (item_take) begin
				pix_q       <= item_pixel;
				last_q      <= item.last;
				scan_open_q <= 1'b0;
				if (item.kind == K_SCAN) begin
					scan_open_q <= !item.last;
					if (!scan_open_q) begin
						min_q      <= item_pixel;
						max_q      <= item_pixel;
						clr_busy_q <= 1'b1;
						clr_ptr_q  <= '0;
					end else begin
						if (item_pixel < min_q) min_q <= item_pixel;
						if (item_pixel > max_q) max_q <= item_pixel;
					end
				end
				if (item.kind == K_FILL) begin
					idx_q <= '0;
				end
			end

			if ((state_q == S_BDIV) && div_done) begin
				idx_q <= (div_quo > NUM_W'(bm1)) ? bm1[ADDR_W-1:0] : div_quo[ADDR_W-1:0];
			end

			if ((state_q == S_BINC) && last_q) begin
				pk_i_q     <= BIN_W'(1);
				pk_v_q     <= 1'b0;
				best_idx_q <= ADDR_W'(1);
				best_cnt_q <= '0;
			end

			if (state_q == S_PEAK) begin
				if (issue) begin
					pk_i_q <= pk_i_q + 1'b1;
				end
				pk_v_q   <= issue;
				pk_idx_q <= pk_i_q[ADDR_W-1:0];
				if (pk_v_q && (rd_q > best_cnt_q)) begin
					best_cnt_q <= rd_q;
					best_idx_q <= pk_idx_q;
				end
			end

			if ((state_q == S_LDIV) && div_done) begin
				lc_q <= lc_n;
				uc_q <= uc_n;
				hv_q <= !clip_bright;
			end

			if ((state_q == S_LSET) && !span2_ok) begin
				recip_q <= '0;
			end
			if ((state_q == S_RDIV) && div_done) begin
				recip_q <= div_quo[31:0];
			end

			if ((state_q == S_MOUT) && out_free) begin
				out_v_q   <= 1'b1;
				out_map_q <= map_val;
				out_end_q <= last_q;
				out_cl_q  <= lc_q;
				out_ch_q  <= uc_q;
			end else if (res_pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign hold      = init_q;
	assign res_valid = out_v_q;
	assign mapped    = out_map_q;
	assign frame_end = out_end_q;
	assign cut_low   = out_cl_q;
	assign cut_high  = out_ch_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BINC) |-> !clr_busy_q)
		else $error("bin update collides with clearing sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		lc_q <= uc_q)
		else $error("lower cut above upper cut");
	assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> clr_busy_q)
		else $error("reset clearing ended early");
	assert property (@(posedge clk) disable iff (!arst_n)
		(item_take && (item.kind == K_FILL)) |-> !clr_busy_q)
		else $error("histogram item started during clearing sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		(((state_q == S_BDIV) || (state_q == S_LDIV) || (state_q == S_RDIV)) && !div_done)
		|-> div_busy)
		else $error("sequencer waits on an idle divider");

endmodule

// ===== rtl/histogram_peak_contrast_stretch.sv =====
// Top level of the histogram peak contrast stretch with gamma 0.3.
// The same frame is streamed three times, the pass chosen by func: pass 0 finds the minimum
// and maximum, pass 1 fills the histogram and, on its last pixel, searches the peak among the
// inner bins and sets the cuts, and pass 2 returns one Q0.16 mapped pixel per input together
// with the cuts in use. Both sides behave like queues: a transfer into the block happens when
// push is high and full is low, and a result transfer happens when pop is high and empty is
// low. A four-entry input queue feeds a sequencer, so the source keeps pushing while a result
// waits. Per item, a scan pixel or an ignored selector stays in the idle state; a mapped pixel
// passes the multiply, table and output states, waiting in the last for a free result register;
// a histogram pixel increments its bin, using the serial bin divider (one quotient bit per
// cycle, 33 bits at the default widths) unless it is at or below the minimum or the frame is
// flat. The last histogram pixel adds a peak search over the inner bins and one or two serial
// divisions. The bin memory is cleared by a sweep over all MAX_BINS entries after reset, during
// which full stays high, and again in the background at each frame start; histogram pixels
// wait for that sweep to finish. Configuration writes (cfg_we, cfg_index, cfg_data) take
// effect on the next clock edge and are meant for when the block is idle.
module histogram_peak_contrast_stretch #(
	parameter int MAX_BINS         = 1024,
	parameter int PIXEL_BITS       = 16,
	parameter int COUNT_BITS       = 20,
	parameter int GAMMA_TABLE_BITS = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic [1:0]                  func,
	input  logic [PIXEL_BITS-1:0]       pixel,
	input  logic                        last,
	output logic                        empty,
	input  logic                        pop,
	output logic [hpcs_pkg::OUT_W-1:0]  mapped,
	output logic                        frame_end,
	output logic [PIXEL_BITS-1:0]       cut_low,
	output logic [PIXEL_BITS-1:0]       cut_high,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [hpcs_pkg::CFG_W-1:0]  cfg_data
);
	import hpcs_pkg::*;

	// Configuration registers.
	logic             clip_bright_q;
	logic [CFG_W-1:0] bin_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_bright_q <= 1'b0;
			bin_count_q   <= BIN_COUNT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CLIP_BRIGHT: clip_bright_q <= cfg_data[0];
				REG_BIN_COUNT:   bin_count_q   <= cfg_data;
				default:         clip_bright_q <= clip_bright_q;
			endcase
		end
	end

	// Queue between the classifying front end and the sequencer.
	logic                  item_valid;
	hpcs_item_t            item;
	logic [PIXEL_BITS-1:0] item_pixel;
	logic                  item_take;
	logic                  hold;
	logic                  res_valid;

	hpcs_front #(.PIXEL_BITS(PIXEL_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.pixel      (pixel),
		.last       (last),
		.hold       (hold),
		.item_valid (item_valid),
		.item       (item),
		.item_pixel (item_pixel),
		.item_take  (item_take)
	);

	hpcs_back #(
		.MAX_BINS         (MAX_BINS),
		.PIXEL_BITS       (PIXEL_BITS),
		.COUNT_BITS       (COUNT_BITS),
		.GAMMA_TABLE_BITS (GAMMA_TABLE_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.clip_bright (clip_bright_q),
		.bin_count   (bin_count_q),
		.item_valid  (item_valid),
		.item        (item),
		.item_pixel  (item_pixel),
		.item_take   (item_take),
		.hold        (hold),
		.res_valid   (res_valid),
		.res_pop     (pop),
		.mapped      (mapped),
		.frame_end   (frame_end),
		.cut_low     (cut_low),
		.cut_high    (cut_high)
	);

	// The result register is the single waiting slot on the output side.
	assign empty = !res_valid;

endmodule

// ===== test/tb_histogram_peak_contrast_stretch.sv =====
// Self-checking testbench of the histogram peak contrast stretch block.
`timescale 1ns / 100ps

module tb_histogram_peak_contrast_stretch;
	import hpcs_pkg::*;

	// The fourth selector code is not used by the block and must be ignored.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;
	localparam int LUT_N     = 1024;
	localparam int LUT_SHIFT = 6;
	localparam int TALLY_DEPTH = 1024;
	// Longest internal activity after the last transfer: peak search plus serial divisions.
	localparam int SETTLE_CYCLES = 1400;

	typedef struct {
		logic [15:0] mapped;
		logic        frame_end;
		logic [15:0] cut_low;
		logic [15:0] cut_high;
	} stretch_result_t;

	// Pseudo float with a 32-bit mantissa used to build the gamma table.
	typedef struct {
		longint unsigned m;
		int              e;
	} pseudo_float_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [1:0]  func;
	logic [15:0] pixel;
	logic        last;
	logic        empty;
	logic        pop;
	logic [15:0] mapped;
	logic        frame_end;
	logic [15:0] cut_low;
	logic [15:0] cut_high;
	logic        cfg_we;
	logic        cfg_index;
	logic [10:0] cfg_data;

	histogram_peak_contrast_stretch u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.func      (func),
		.pixel     (pixel),
		.last      (last),
		.empty     (empty),
		.pop       (pop),
		.mapped    (mapped),
		.frame_end (frame_end),
		.cut_low   (cut_low),
		.cut_high  (cut_high),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the block's state and registers.
	logic [15:0]     gamma_lut [0:LUT_N];
	logic [19:0]     bin_tally [0:TALLY_DEPTH-1];
	logic [15:0]     shadow_min;
	logic [15:0]     shadow_max;
	logic [15:0]     shadow_cut_low;
	logic [15:0]     shadow_cut_high;
	logic [31:0]     shadow_recip;
	logic [15:0]     shadow_high_value;
	logic            shadow_scan_open;
	logic            shadow_clip_bright;
	logic [10:0]     shadow_bin_count;

	stretch_result_t pending_results[$];
	int              error_count;
	int              send_idle_pct;
	int              recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case a handshake never completes.
	initial begin
		#8000000;
		$display("tb_histogram_peak_contrast_stretch: errors");
		$finish;
	end

	function automatic pseudo_float_t pf_norm(longint unsigned v);
		pseudo_float_t r;
		r.m = v;
		r.e = 0;
		while (r.m >= 64'h1_0000_0000) begin
			r.m = r.m >> 1;
			r.e++;
		end
		while (r.m < 64'h8000_0000) begin
			r.m = r.m << 1;
			r.e--;
		end
		return r;
	endfunction

	function automatic pseudo_float_t pf_times(pseudo_float_t a, pseudo_float_t b);
		pseudo_float_t   r;
		longint unsigned p;
		p = a.m * b.m;
		r.e = a.e + b.e;
		if (p[63]) begin
			r.m = p >> 32;
			r.e += 32;
		end else begin
			r.m = p >> 31;
			r.e += 31;
		end
		return r;
	endfunction

	function automatic pseudo_float_t pf_power(pseudo_float_t a, int n);
		pseudo_float_t r;
		r = a;
		for (int i = 1; i < n; i++) r = pf_times(r, a);
		return r;
	endfunction

	// Entry k is the largest y with y^10 * N^3 <= k^3 * 65535^10, i.e. y = 65535*(k/N)^0.3.
	function automatic void build_gamma_lut();
		pseudo_float_t full10;
		pseudo_float_t n3;
		pseudo_float_t rhs;
		pseudo_float_t lhs;
		int            lo;
		int            hi;
		int            mid;
		full10 = pf_power(pf_norm(65535), 10);
		n3 = pf_power(pf_norm(LUT_N), 3);
		gamma_lut[0] = 16'd0;
		for (int k = 1; k <= LUT_N; k++) begin
			rhs = pf_times(pf_power(pf_norm(k), 3), full10);
			lo = 1;
			hi = 65535;
			while (lo < hi) begin
				mid = lo + (hi - lo + 1) / 2;
				lhs = pf_times(pf_power(pf_norm(mid), 10), n3);
				if (lhs.e < rhs.e || (lhs.e == rhs.e && lhs.m <= rhs.m)) lo = mid;
				else hi = mid - 1;
			end
			gamma_lut[k] = lo[15:0];
		end
	endfunction

	function automatic int active_bins();
		if (shadow_bin_count < 3) return 3;
		if (shadow_bin_count > TALLY_DEPTH) return TALLY_DEPTH;
		return int'(shadow_bin_count);
	endfunction

	function automatic longint unsigned frame_span();
		return (shadow_max > shadow_min) ? longint'(shadow_max - shadow_min) : 0;
	endfunction

	function automatic void clear_tally();
		for (int i = 0; i < TALLY_DEPTH; i++) bin_tally[i] = '0;
	endfunction

	// End-of-histogram work: the inner bin with the largest count sets the cuts and the reciprocal.
	function automatic void search_peak();
		int              nb;
		int              best;
		longint unsigned span;
		longint unsigned den;
		logic [15:0]     top;
		nb = active_bins();
		best = 1;
		span = frame_span();
		den = 64'(nb - 1);
		for (int i = 2; i + 1 < nb; i++)
			if (bin_tally[i] > bin_tally[best]) best = i;
		shadow_cut_low = 16'(longint'(shadow_min) + (2 * best * span + den) / (2 * den));
		top = (shadow_max > shadow_cut_low) ? shadow_max : shadow_cut_low;
		if (shadow_clip_bright) begin
			shadow_cut_high = top - ((top - shadow_cut_low) >> 1);
			shadow_high_value = 16'd0;
		end else begin
			shadow_cut_high = top;
			shadow_high_value = 16'hFFFF;
		end
		if (shadow_cut_high - shadow_cut_low >= 2)
			shadow_recip = 32'((64'd1 << 32) / longint'(shadow_cut_high - shadow_cut_low));
		else
			shadow_recip = '0;
	endfunction

	function automatic logic [15:0] stretch_pixel(logic [15:0] p);
		longint unsigned norm;
		int              idx;
		int              frac;
		logic [15:0]     a;
		logic [15:0]     b;
		if (p >= shadow_cut_high) return shadow_high_value;
		if (p <= shadow_cut_low) return 16'd0;
		norm = (longint'(p - shadow_cut_low) * longint'(shadow_recip)) >> 16;
		if (norm > 65535) norm = 65535;
		idx = int'(norm >> LUT_SHIFT);
		frac = int'(norm & ((1 << LUT_SHIFT) - 1));
		a = gamma_lut[idx];
		b = gamma_lut[idx + 1];
		return a + 16'((longint'(b - a) * frac) >> LUT_SHIFT);
	endfunction

	// Advances the shadow state by one accepted item and queues the result it causes.
	function automatic void predict_item(logic [1:0] f, logic [15:0] p, logic lst);
		int              nb;
		longint unsigned span;
		longint unsigned idx;
		stretch_result_t r;
		if (f == FUNC_SCAN) begin
			if (!shadow_scan_open) begin
				shadow_min = p;
				shadow_max = p;
				clear_tally();
				shadow_scan_open = 1'b1;
			end else begin
				if (p < shadow_min) shadow_min = p;
				if (p > shadow_max) shadow_max = p;
			end
			if (lst) shadow_scan_open = 1'b0;
			return;
		end
		shadow_scan_open = 1'b0;
		if (f == FUNC_FILL) begin
			nb = active_bins();
			span = frame_span();
			idx = 0;
			if (span != 0 && p > shadow_min) begin
				idx = (2 * longint'(p - shadow_min) * (nb - 1) + span) / (2 * span);
				if (idx > nb - 1) idx = nb - 1;
			end
			if (bin_tally[idx] != 20'hFFFFF) bin_tally[idx]++;
			if (lst) search_peak();
		end else if (f == FUNC_MAP) begin
			r.mapped = stretch_pixel(p);
			r.frame_end = lst;
			r.cut_low = shadow_cut_low;
			r.cut_high = shadow_cut_high;
			pending_results.push_back(r);
		end
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// Result side: pop is chosen at each falling edge, a transfer is checked at the rising edge.
	initial begin
		stretch_result_t want;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			pop = ($urandom_range(99) >= recv_stall_pct);
			@(posedge clk);
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, mapped", mapped, 16'd0);
				end else begin
					want = pending_results.pop_front();
					if (mapped !== want.mapped) report_mismatch("mapped", mapped, want.mapped);
					if (frame_end !== want.frame_end)
						report_mismatch("frame_end", frame_end, want.frame_end);
					if (cut_low !== want.cut_low) report_mismatch("cut_low", cut_low, want.cut_low);
					if (cut_high !== want.cut_high)
						report_mismatch("cut_high", cut_high, want.cut_high);
				end
			end
		end
	end

	// Sends one item; enters and leaves just after a falling edge.
	task automatic push_pixel(logic [1:0] f, logic [15:0] p, logic lst);
		while ($urandom_range(99) < send_idle_pct) @(negedge clk);
		push = 1'b1;
		func = f;
		pixel = p;
		last = lst;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_item(f, p, lst);
		@(negedge clk);
		push = 1'b0;
		func = 2'($urandom_range(3));
		pixel = 16'($urandom);
		last = 1'($urandom_range(1));
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	// Register writes happen only once the block has gone quiet.
	task automatic write_register(logic idx, logic [10:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == REG_CLIP_BRIGHT) shadow_clip_bright = value[0];
		else shadow_bin_count = value;
	endtask

	// Streams one frame through all three passes.
	task automatic run_frame(int n, logic [15:0] base, logic [15:0] range, bit noisy);
		logic [15:0] px [0:63];
		for (int i = 0; i < n; i++) px[i] = 16'(base + $urandom_range(range));
		for (int i = 0; i < n; i++) push_pixel(FUNC_SCAN, px[i], i == n - 1);
		for (int i = 0; i < n; i++)
			push_pixel(FUNC_FILL, (noisy && $urandom_range(7) == 0) ? 16'($urandom) : px[i],
				i == n - 1);
		if (noisy && $urandom_range(1))
			push_pixel(FUNC_UNUSED, 16'($urandom), 1'($urandom_range(1)));
		for (int i = 0; i < n; i++)
			push_pixel(FUNC_MAP, (noisy && $urandom_range(5) == 0) ? 16'($urandom) : px[i],
				i == n - 1);
	endtask

	// Reset cuts, the ignored selector, an empty scan, a flat frame and a full-scale frame.
	task automatic test_directed();
		push_pixel(FUNC_MAP, 16'd0, 1'b0);
		push_pixel(FUNC_MAP, 16'd1234, 1'b0);
		push_pixel(FUNC_MAP, 16'hFFFF, 1'b1);
		push_pixel(FUNC_UNUSED, 16'hFFFF, 1'b1);
		// A histogram with no scan since reset sees min above max.
		push_pixel(FUNC_FILL, 16'hFFFF, 1'b0);
		push_pixel(FUNC_FILL, 16'd0, 1'b1);
		push_pixel(FUNC_MAP, 16'd7, 1'b1);
		write_register(REG_BIN_COUNT, 11'd3);
		// Flat frame: every histogram pixel lands in bin 0.
		push_pixel(FUNC_SCAN, 16'd5, 1'b0);
		push_pixel(FUNC_SCAN, 16'd5, 1'b1);
		push_pixel(FUNC_FILL, 16'd5, 1'b0);
		push_pixel(FUNC_FILL, 16'd9, 1'b1);
		push_pixel(FUNC_MAP, 16'd4, 1'b0);
		push_pixel(FUNC_MAP, 16'd6, 1'b1);
		write_register(REG_CLIP_BRIGHT, 11'd1);
		write_register(REG_BIN_COUNT, 11'd4);
		push_pixel(FUNC_SCAN, 16'd30000, 1'b0);
		push_pixel(FUNC_SCAN, 16'd0, 1'b0);
		push_pixel(FUNC_SCAN, 16'hFFFF, 1'b1);
		push_pixel(FUNC_FILL, 16'd30000, 1'b0);
		push_pixel(FUNC_FILL, 16'd0, 1'b0);
		push_pixel(FUNC_FILL, 16'hFFFF, 1'b1);
		push_pixel(FUNC_MAP, 16'd0, 1'b0);
		push_pixel(FUNC_MAP, 16'd40000, 1'b0);
		push_pixel(FUNC_MAP, 16'hFFFF, 1'b1);
	endtask

	// Register extremes: bin counts below the clamp, the largest count and all ones.
	task automatic test_bin_extremes();
		write_register(REG_BIN_COUNT, 11'd0);
		run_frame(5, 16'd100, 16'd900, 1'b0);
		write_register(REG_BIN_COUNT, 11'd2047);
		run_frame(6, 16'd0, 16'hFFFF, 1'b0);
		write_register(REG_CLIP_BRIGHT, 11'd0);
		write_register(REG_BIN_COUNT, 11'd1024);
		run_frame(4, 16'd0, 16'hFFFF, 1'b1);
	endtask

	// Random frames over the four idling phases.
	task automatic test_random_frames();
		int n;
		int idle_table [4][2] = '{'{0, 0}, '{85, 0}, '{0, 85}, '{18, 18}};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_table[ph][0];
			recv_stall_pct = idle_table[ph][1];
			for (int fr = 0; fr < 5; fr++) begin
				n = $urandom_range(16, 4);
				write_register(REG_CLIP_BRIGHT, 11'($urandom_range(1)));
				write_register(REG_BIN_COUNT, ($urandom_range(5) == 0) ? 11'($urandom) :
					11'($urandom_range(8, 2)));
				if ($urandom_range(1)) run_frame(n, 16'd0, 16'hFFFF, $urandom_range(3) == 0);
				else run_frame(n, 16'($urandom), 16'($urandom_range(4000)),
					$urandom_range(3) == 0);
				// Let the result side run dry once per phase.
				if (fr == 2) wait_drained();
			end
		end
	endtask

	// Broken sequences: stray selectors and passes out of order.
	task automatic test_noise();
		send_idle_pct = 18;
		recv_stall_pct = 18;
		for (int i = 0; i < 40; i++)
			push_pixel(2'($urandom_range(3)), 16'($urandom), $urandom_range(3) == 0);
	endtask

	initial begin
		error_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		push = 1'b0;
		func = FUNC_SCAN;
		pixel = '0;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_CLIP_BRIGHT;
		cfg_data = '0;
		build_gamma_lut();
		shadow_min = 16'hFFFF;
		shadow_max = '0;
		clear_tally();
		shadow_cut_low = '0;
		shadow_cut_high = 16'hFFFF;
		shadow_recip = '0;
		shadow_high_value = 16'hFFFF;
		shadow_scan_open = 1'b0;
		shadow_clip_bright = 1'b0;
		shadow_bin_count = BIN_COUNT_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_bin_extremes();
		test_random_frames();
		test_noise();

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0) begin
			$display("tb_histogram_peak_contrast_stretch: clean");
		end else begin
			$display("tb_histogram_peak_contrast_stretch: errors");
		end
		$finish;
	end

endmodule
